// ----- rtl/lbm_pkg.sv -----
// Package: types, constants and helpers for the D2Q9 BGK collision block
package lbm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int OMEGA_FRAC = 12;
  localparam int NDIR = 9;
  localparam logic [12:0] OMEGA_RESET = 13'd7728;
  localparam int DIV_STEPS = 34;

  typedef struct packed {
    logic signed [15:0] pop_d0;
    logic signed [15:0] pop_d1;
    logic signed [15:0] pop_d2;
    logic signed [15:0] pop_d3;
    logic signed [15:0] pop_d4;
    logic signed [15:0] pop_d5;
    logic signed [15:0] pop_d6;
    logic signed [15:0] pop_d7;
    logic signed [15:0] pop_d8;
    logic               solid_cell;
  } cell_req_t;

  typedef struct packed {
    logic signed [15:0] post_d0;
    logic signed [15:0] post_d1;
    logic signed [15:0] post_d2;
    logic signed [15:0] post_d3;
    logic signed [15:0] post_d4;
    logic signed [15:0] post_d5;
    logic signed [15:0] post_d6;
    logic signed [15:0] post_d7;
    logic signed [15:0] post_d8;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               density_fault;
  } cell_res_t;

  typedef logic signed [15:0] pop_arr_t [NDIR];

  // Direction tables
  function automatic logic signed [1:0] dir_x(input int i);
    unique case (i)
      2, 3, 4: dir_x = 2'sd1;
      6, 7, 8: dir_x = -2'sd1;
      default: dir_x = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_y(input int i);
    unique case (i)
      1, 2, 8: dir_y = 2'sd1;
      4, 5, 6: dir_y = -2'sd1;
      default: dir_y = 2'sd0;
    endcase
  endfunction

  function automatic int opp_dir(input int i);
    opp_dir = (i == 0) ? 0 : ((i <= 4) ? i + 4 : i - 4);
  endfunction

  function automatic logic [4:0] wt36(input int i);
    wt36 = (i == 0) ? 5'd16 : ((i % 2 == 1) ? 5'd4 : 5'd1);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) sat16 = 16'sh7fff;
    else if (v < -64'sd32768) sat16 = -16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

// ----- rtl/lbm_div.sv -----
// Pipelined restoring divider for the velocity quotient, one quotient bit per stage
module lbm_div (
  input  logic               clk,
  input  logic signed [31:0] num,
  input  logic signed [19:0] den,
  output logic signed [15:0] quo
);
  import lbm_pkg::*;

  logic [33:0] rem_s [DIV_STEPS+1];
  logic [33:0] q_s   [DIV_STEPS+1];
  logic [19:0] d_s   [DIV_STEPS+1];
  logic        neg_s [DIV_STEPS+1];

  // Magnitudes into stage zero
  always_comb begin
    rem_s[0] = '0;
    q_s[0]   = num[31] ? 34'(-{{2{num[31]}}, num}) : 34'({2'b00, num});
    d_s[0]   = den[19] ? 20'(-den) : den;
    neg_s[0] = num[31] ^ den[19];
  end

  // One quotient bit a stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_st
    logic [34:0] sh;
    logic [34:0] df;
    always_comb begin
      sh = {rem_s[s], q_s[s][33]};
      df = sh - {15'd0, d_s[s]};
    end
    always_ff @(posedge clk) begin
      rem_s[s+1] <= df[34] ? sh[33:0] : df[33:0];
      q_s[s+1]   <= {q_s[s][32:0], ~df[34]};
      d_s[s+1]   <= d_s[s];
      neg_s[s+1] <= neg_s[s];
    end
  end

  // Sign and saturate
  always_comb begin
    logic signed [63:0] t;
    t = neg_s[DIV_STEPS] ? -$signed({30'd0, q_s[DIV_STEPS]})
                         : $signed({30'd0, q_s[DIV_STEPS]});
    quo = sat16(t);
  end
endmodule

// ----- rtl/lbm_lane.sv -----
// One direction lane: equilibrium and relaxation over five registered stages
module lbm_lane (
  input  logic               clk,
  input  logic signed [1:0]  cx,
  input  logic signed [1:0]  cy,
  input  logic        [4:0]  wt,
  input  logic signed [15:0] f,
  input  logic signed [19:0] rho,
  input  logic signed [15:0] ux,
  input  logic signed [15:0] uy,
  input  logic signed [32:0] usq,
  input  logic        [12:0] omega,
  output logic signed [15:0] post
);
  import lbm_pkg::*;

  localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
  // Division by 36 * ONE: round, shift out 4 * ONE, then multiply by a reciprocal of 9
  localparam logic [47:0] FEQ_HALF = 48'd18 << FRAC_BITS;
  localparam int FEQ_SHIFT = FRAC_BITS + 2;
  localparam logic [31:0] RECIP9 = 32'd3817748708;
  localparam int RECIP9_SHIFT = 35;

  logic signed [47:0] br2_r, b_c, p_r;
  logic signed [23:0] b_r;
  logic signed [19:0] rho_r, rho_r2, cu;
  logic signed [15:0] f_r, f_r2, f_r3, f_r4, f_r5;
  logic        [47:0] mag_c;
  logic        [30:0] nq_c;
  logic        [62:0] qm_c;
  logic signed [29:0] feq_c, e_r;
  logic signed [43:0] d_r, m_c;

  // Bracket term
  always_comb begin
    cu = 20'(3 * (20'(cx) * ux + 20'(cy) * uy));
  end
  always_ff @(posedge clk) begin
    br2_r <= 2*ONE*ONE + 2*48'(cu)*ONE + 48'(cu)*48'(cu) - 3*48'(usq);
    rho_r <= rho;
    f_r   <= f;
  end

  // Round bracket
  always_comb begin
    b_c = br2_r >= 0 ? (br2_r + ONE) / (2*ONE) : -((-br2_r + ONE) / (2*ONE));
  end
  always_ff @(posedge clk) begin
    b_r    <= 24'(b_c);
    rho_r2 <= rho_r;
    f_r2   <= f_r;
  end

  // Scale by density and weight
  always_ff @(posedge clk) begin
    p_r  <= rho_r2 * b_r * $signed({1'b0, wt});
    f_r3 <= f_r2;
  end

  // Equilibrium, then its distance from the population
  always_comb begin
    mag_c = p_r[47] ? 48'(-p_r) + FEQ_HALF : 48'(p_r) + FEQ_HALF;
    nq_c  = mag_c[FEQ_SHIFT+30:FEQ_SHIFT];
    qm_c  = nq_c * RECIP9;
    feq_c = p_r[47] ? -$signed({2'b00, qm_c[62:RECIP9_SHIFT]})
                    : $signed({2'b00, qm_c[62:RECIP9_SHIFT]});
  end
  always_ff @(posedge clk) begin
    e_r  <= feq_c - 30'(f_r3);
    f_r4 <= f_r3;
  end

  // Weight by the relaxation rate
  always_ff @(posedge clk) begin
    d_r  <= $signed({1'b0, omega}) * e_r;
    f_r5 <= f_r4;
  end

  // Round and relax
  always_comb begin
    m_c = d_r >= 0 ? (d_r + (44'sd1 <<< (OMEGA_FRAC-1))) >>> OMEGA_FRAC
                   : -((-d_r + (44'sd1 <<< (OMEGA_FRAC-1))) >>> OMEGA_FRAC);
    post = sat16(64'(f_r5) + 64'(m_c));
  end
endmodule

// ----- rtl/d2q9_bgk_cell_collision_top.sv -----
// Top level: moments, velocity divider, nine collision lanes, result register
//
// Accepts one cell every clock (busy stays low). A result strobes out after
// its request has passed 1 moment stage, 34 divider stages, 1 usq stage,
// 5 lane stages and the output register; the divider pipeline is the
// longest part of that path. Results cannot be held off; take each on its strobe.
module d2q9_bgk_cell_collision_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lbm_pkg::cell_req_t  req,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_data,
  output logic                done,
  output lbm_pkg::cell_res_t  res
);
  import lbm_pkg::*;

  localparam int LAT = DIV_STEPS + 1;

  logic [12:0] omega;
  pop_arr_t f_in, g_in;
  logic signed [19:0] rho_c, jx_c, jy_c, rho_m;
  logic signed [31:0] nx, ny;
  logic fault_c, solid_m, fault_m, vx_ok, vy_ok;
  logic signed [15:0] qx, qy, ux, uy;
  pop_arr_t fdl [LAT];
  logic signed [19:0] rdl [LAT];
  logic fsl [LAT], fdfl [LAT], vdl [LAT+6];
  logic signed [15:0] ux_r, uy_r, uxd [6], uyd [6];
  logic signed [32:0] usq_r;
  logic signed [19:0] rho_u;
  pop_arr_t f_u;
  logic fault_d [6];
  logic signed [15:0] post [NDIR];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) omega <= OMEGA_RESET;
    else if (cfg_we) omega <= cfg_data;
  end

  // Moments
  always_comb begin
    f_in = '{req.pop_d0, req.pop_d1, req.pop_d2, req.pop_d3, req.pop_d4,
             req.pop_d5, req.pop_d6, req.pop_d7, req.pop_d8};
    rho_c = '0; jx_c = '0; jy_c = '0;
    for (int i = 0; i < NDIR; i++) begin
      rho_c += 20'(f_in[i]);
      jx_c  += 20'(dir_x(i)) * 20'(f_in[i]);
      jy_c  += 20'(dir_y(i)) * 20'(f_in[i]);
      g_in[i] = req.solid_cell ? f_in[opp_dir(i)] : f_in[i];
    end
    fault_c = rho_c <= 0;
  end
  always_ff @(posedge clk) begin
    rho_m   <= rho_c;
    nx      <= 32'(jx_c) <<< FRAC_BITS;
    ny      <= 32'(jy_c) <<< FRAC_BITS;
    solid_m <= req.solid_cell;
    fault_m <= fault_c;
    fdl[0]  <= g_in;
    rdl[0]  <= rho_c;
    fsl[0]  <= req.solid_cell;
    fdfl[0] <= fault_c;
  end
  assign vx_ok = !solid_m && !fault_m;
  assign vy_ok = vx_ok;

  lbm_div u_divx (.clk, .num(nx), .den(vx_ok ? rho_m : 20'sd1), .quo(qx));
  lbm_div u_divy (.clk, .num(ny), .den(vy_ok ? rho_m : 20'sd1), .quo(qy));

  // Delay line alongside the divider
  for (genvar s = 1; s < LAT; s++) begin : g_dl
    always_ff @(posedge clk) begin
      fdl[s] <= fdl[s-1]; rdl[s] <= rdl[s-1];
      fsl[s] <= fsl[s-1]; fdfl[s] <= fdfl[s-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) for (int s = 0; s < LAT+6; s++) vdl[s] <= 1'b0;
    else begin
      vdl[0] <= start;
      for (int s = 1; s < LAT+6; s++) vdl[s] <= vdl[s-1];
    end
  end

  // Zero velocity for solid or faulty cells, then |u|^2
  assign ux = (fsl[LAT-1] || fdfl[LAT-1]) ? 16'sd0 : qx;
  assign uy = (fsl[LAT-1] || fdfl[LAT-1]) ? 16'sd0 : qy;
  always_ff @(posedge clk) begin
    ux_r  <= ux; uy_r <= uy;
    usq_r <= 33'(32'(ux) * 32'(ux)) + 33'(32'(uy) * 32'(uy));
    rho_u <= rdl[LAT-1]; f_u <= fdl[LAT-1];
    fault_d[0] <= fdfl[LAT-1];
    uxd[0] <= ux; uyd[0] <= uy;
    for (int s = 1; s < 6; s++) begin
      uxd[s] <= uxd[s-1]; uyd[s] <= uyd[s-1]; fault_d[s] <= fault_d[s-1];
    end
  end

  // One lane per direction
  for (genvar i = 0; i < NDIR; i++) begin : g_lane
    lbm_lane u_lane (.clk, .cx(dir_x(i)), .cy(dir_y(i)), .wt(wt36(i)),
      .f(f_u[i]), .rho(rho_u), .ux(ux_r), .uy(uy_r), .usq(usq_r), .omega,
      .post(post[i]));
  end

  // Merge lanes into the result register
  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : vdl[LAT+5];
    res  <= '{post[0], post[1], post[2], post[3], post[4], post[5], post[6],
              post[7], post[8], uxd[5], uyd[5], fault_d[5]};
  end

  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $past(vdl[LAT+5]) |-> done) else $error("result strobe lost");
  a_solid: assert property (@(posedge clk) disable iff (rst)
    done && $past(fsl[LAT-1], 7) |-> res.vel_x == 0 && res.vel_y == 0)
    else $error("solid cell with velocity");
endmodule
